/* hdl/rgb_pixel_format_packer_core_defines.svh */
// Assertion macros shared by the RGB pixel packer RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef RGB_PIXEL_FORMAT_PACKER_CORE_DEFINES_SVH
`define RGB_PIXEL_FORMAT_PACKER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define RPFP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rpfp assertion failed");

// Next-cycle implication, checked out of reset
`define RPFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rpfp assertion failed");

`endif

/* hdl/rpfp_pkg.sv */
// Shared types and constants for the RGB pixel format packer.
// No dependencies; imported by rpfp_chan and rgb_pixel_format_packer_core.
`default_nettype none

package rpfp_pkg;

  localparam int unsigned CHAN_BITS     = 8;
  localparam int unsigned PIX_BITS      = 32;
  localparam int unsigned POS_BITS      = 5;
  localparam int unsigned SIZE_BITS     = 4;
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 5;
  localparam int unsigned PIXEL_WIDTH_DEF = 32;

  // Register indexes on the config port
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_RGB_MODE   = 3'd0,
    REG_RED_POS    = 3'd1,
    REG_RED_SIZE   = 3'd2,
    REG_GREEN_POS  = 3'd3,
    REG_GREEN_SIZE = 3'd4,
    REG_BLUE_POS   = 3'd5,
    REG_BLUE_SIZE  = 3'd6
  } cfg_reg_t;

  // Placement of one color field in the pixel
  typedef struct packed {
    logic [POS_BITS-1:0]  pos;
    logic [SIZE_BITS-1:0] size;
  } chan_cfg_t;

endpackage

`default_nettype wire

/* hdl/rpfp_chan.sv */
// One color channel: narrows and places it (encode), or extracts and widens it (decode).
// Depends on rpfp_pkg.
`default_nettype none

module rpfp_chan #(
  parameter int unsigned PIXEL_WIDTH = rpfp_pkg::PIXEL_WIDTH_DEF
) (
  input  wire logic [rpfp_pkg::CHAN_BITS-1:0] chan_in,
  input  wire logic [rpfp_pkg::PIX_BITS-1:0]  pixel_in,
  input  wire rpfp_pkg::chan_cfg_t            cfg,
  output logic      [rpfp_pkg::PIX_BITS-1:0]  packed_out,
  output logic      [rpfp_pkg::CHAN_BITS-1:0] wide_out
);
  import rpfp_pkg::*;

  localparam logic [63:0]         MASK64   = (64'd1 << PIXEL_WIDTH) - 64'd1;
  localparam logic [PIX_BITS-1:0] PIX_MASK = MASK64[PIX_BITS-1:0];

  logic                  size_ok;
  logic [CHAN_BITS-1:0]  narrowed;
  logic [SIZE_BITS-1:0]  drop;
  logic [PIX_BITS-1:0]   field;

  // Sizes 1..8 are valid; anything else gives zero both ways
  assign size_ok = (cfg.size != '0) && (cfg.size <= SIZE_BITS'(CHAN_BITS));
  assign drop    = SIZE_BITS'(CHAN_BITS) - cfg.size;

  // Encode: drop low bits, move to the field position, clip at pixel top
  always_comb begin
    narrowed   = chan_in >> drop;
    packed_out = '0;
    if (size_ok) begin
      packed_out = ({{(PIX_BITS-CHAN_BITS){1'b0}}, narrowed} << cfg.pos) & PIX_MASK;
    end
  end

  // Decode: extract, then repeat the field from the top bit downward
  assign field = pixel_in >> cfg.pos;

  always_comb begin
    case (cfg.size)
      4'd1:    wide_out = {8{field[0]}};
      4'd2:    wide_out = {4{field[1:0]}};
      4'd3:    wide_out = {field[2:0], field[2:0], field[2:1]};
      4'd4:    wide_out = {2{field[3:0]}};
      4'd5:    wide_out = {field[4:0], field[4:2]};
      4'd6:    wide_out = {field[5:0], field[5:4]};
      4'd7:    wide_out = {field[6:0], field[6]};
      4'd8:    wide_out = field[7:0];
      default: wide_out = '0;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/rgb_pixel_format_packer_core.sv */
// RGB pixel format packer: encodes three 8-bit channels into a pixel or decodes one back.
// Top level; depends on rpfp_pkg, rpfp_chan and rgb_pixel_format_packer_core_defines.svh.
//
// Usage:
//   Input beats arrive on in_*; in_tuser selects encode (0) or decode (1). Each input
//   beat yields exactly one output beat on out_*, in order. Encode fills the pixel
//   field and zeroes the channels; decode does the reverse. With rgb_mode clear every
//   output field is zero.
//   Registers are written through cfg_we/cfg_index/cfg_wdata; write them only while
//   no beat is in flight. Unknown indexes are ignored.
// Pipeline and throughput:
//   Two register stages (input register, result register): a beat waits in the input
//   register until the result register is free. One beat per cycle sustained while
//   out_tready is high; conversion is a single pass of shifts and muxes per channel.
// Reset:
//   rst_n is synchronous, active low. Both stages empty; registers return to
//   rgb_mode 0, red at bit 16, green at bit 8, blue at bit 0, all sizes 8.
// Backpressure:
//   While out_tready is low the result holds; the input register still takes one more
//   beat, after which in_tready drops until the result is taken.
`default_nettype none

module rgb_pixel_format_packer_core #(
  parameter int unsigned PIXEL_WIDTH = rpfp_pkg::PIXEL_WIDTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // Input channel
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  // tdata: red_in[7:0], green_in[15:8], blue_in[23:16], pixel_in[55:24]
  input  wire logic [55:0]                           in_tdata,
  // tuser: req_type[0]
  input  wire logic                                  in_tuser,
  // Result channel
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  // tdata: pixel_out[31:0], red_out[39:32], green_out[47:40], blue_out[55:48]
  output logic      [55:0]                           out_tdata,
  // Configuration write port
  input  wire logic                                  cfg_we,
  input  wire logic [rpfp_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  wire logic [rpfp_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);
  import rpfp_pkg::*;

  `include "rgb_pixel_format_packer_core_defines.svh"

  localparam logic [63:0]         MASK64   = (64'd1 << PIXEL_WIDTH) - 64'd1;
  localparam logic [PIX_BITS-1:0] PIX_MASK = MASK64[PIX_BITS-1:0];

  // Configuration registers
  logic      rgb_mode_r;
  chan_cfg_t red_cfg_r, green_cfg_r, blue_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rgb_mode_r  <= 1'b0;
      red_cfg_r   <= '{pos: 5'd16, size: 4'd8};
      green_cfg_r <= '{pos: 5'd8,  size: 4'd8};
      blue_cfg_r  <= '{pos: 5'd0,  size: 4'd8};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RGB_MODE:   rgb_mode_r       <= cfg_wdata[0];
        REG_RED_POS:    red_cfg_r.pos    <= cfg_wdata;
        REG_RED_SIZE:   red_cfg_r.size   <= cfg_wdata[SIZE_BITS-1:0];
        REG_GREEN_POS:  green_cfg_r.pos  <= cfg_wdata;
        REG_GREEN_SIZE: green_cfg_r.size <= cfg_wdata[SIZE_BITS-1:0];
        REG_BLUE_POS:   blue_cfg_r.pos   <= cfg_wdata;
        REG_BLUE_SIZE:  blue_cfg_r.size  <= cfg_wdata[SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake
  logic s1_valid_r, out_valid_r;
  logic out_free, s1_move, in_fire;

  assign out_free   = !out_valid_r || out_tready;
  assign s1_move    = s1_valid_r && out_free;
  assign in_tready  = !s1_valid_r || out_free;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Input register
  logic                 s1_dec_r;
  logic [CHAN_BITS-1:0] s1_red_r, s1_green_r, s1_blue_r;
  logic [PIX_BITS-1:0]  s1_pixel_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_dec_r   <= in_tuser;
      s1_red_r   <= in_tdata[7:0];
      s1_green_r <= in_tdata[15:8];
      s1_blue_r  <= in_tdata[23:16];
      s1_pixel_r <= in_tdata[55:24] & PIX_MASK;
    end
  end

  // Per-channel conversion
  logic [PIX_BITS-1:0]  red_pk, green_pk, blue_pk;
  logic [CHAN_BITS-1:0] red_wd, green_wd, blue_wd;

  rpfp_chan #(.PIXEL_WIDTH(PIXEL_WIDTH)) u_red (
    .chan_in(s1_red_r), .pixel_in(s1_pixel_r), .cfg(red_cfg_r),
    .packed_out(red_pk), .wide_out(red_wd)
  );
  rpfp_chan #(.PIXEL_WIDTH(PIXEL_WIDTH)) u_green (
    .chan_in(s1_green_r), .pixel_in(s1_pixel_r), .cfg(green_cfg_r),
    .packed_out(green_pk), .wide_out(green_wd)
  );
  rpfp_chan #(.PIXEL_WIDTH(PIXEL_WIDTH)) u_blue (
    .chan_in(s1_blue_r), .pixel_in(s1_pixel_r), .cfg(blue_cfg_r),
    .packed_out(blue_pk), .wide_out(blue_wd)
  );

  // Result select and register
  logic [PIX_BITS-1:0]  pix_nxt, pix_r;
  logic [CHAN_BITS-1:0] red_nxt, green_nxt, blue_nxt;
  logic [CHAN_BITS-1:0] red_r, green_r, blue_r;

  always_comb begin
    pix_nxt   = '0;
    red_nxt   = '0;
    green_nxt = '0;
    blue_nxt  = '0;
    if (rgb_mode_r) begin
      if (s1_dec_r) begin
        red_nxt   = red_wd;
        green_nxt = green_wd;
        blue_nxt  = blue_wd;
      end else begin
        pix_nxt = red_pk | green_pk | blue_pk;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      pix_r   <= pix_nxt;
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_tdata = {blue_r, green_r, red_r, pix_r};

  // Checks
  `RPFP_ASSERT_NEXT(a_stage_drains, clk, rst_n, s1_valid_r && !out_valid_r, out_valid_r)
  `RPFP_ASSERT_SAME(a_no_overrun, clk, rst_n, in_fire, !s1_valid_r || s1_move)
  `RPFP_ASSERT_SAME(a_one_kind, clk, rst_n, out_valid_r,
                    pix_r == '0 || {red_r, green_r, blue_r} == '0)

endmodule

`default_nettype wire

/* tb/sv/rpfp_tb_pkg.sv */
// Request codes shared by the pixel packer testbench files.
// No dependencies; imported by rpfp_result_checker and tb_top.
package rpfp_tb_pkg;

  // Meaning of in_tuser
  typedef enum logic {
    REQ_ENCODE = 1'b0,
    REQ_DECODE = 1'b1
  } px_req_t;

endpackage

/* tb/sv/rpfp_result_checker.sv */
// Checker for the RGB pixel packer: tracks register writes, predicts each result beat
// and compares it with the output channel. Depends on rpfp_pkg and rpfp_tb_pkg.
module rpfp_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  // tdata: red_in[7:0], green_in[15:8], blue_in[23:16], pixel_in[55:24]
  input  logic [55:0] in_tdata,
  // tuser: req_type[0]
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  // tdata: pixel_out[31:0], red_out[39:32], green_out[47:40], blue_out[55:48]
  input  logic [55:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [4:0]  cfg_wdata,
  output int          pending_cnt,
  output int          error_cnt,
  output int          checked_cnt
);
  import rpfp_pkg::*;
  import rpfp_tb_pkg::*;

  // Result beat, laid out as out_tdata
  typedef struct packed {
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [31:0] pixel;
  } px_result_t;

  // Local copy of the format registers
  logic      rgb_mode;
  chan_cfg_t red_fmt, green_fmt, blue_fmt;

  px_result_t expected_px[$];

  // Narrow a channel to its field width and move it to its bit position
  function automatic logic [31:0] place_chan(logic [7:0] chan, logic [3:0] width,
                                             logic [4:0] lsb);
    logic [31:0] narrowed;
    narrowed = '0;
    if (width != 0 && width <= 8) begin
      narrowed = {24'd0, chan} >> (8 - width);
      narrowed = narrowed << lsb;
    end
    return narrowed;
  endfunction

  // Pull a field out of the pixel and widen it by repeating its top bits
  function automatic logic [7:0] widen_chan(logic [31:0] pix, logic [3:0] width,
                                            logic [4:0] lsb);
    int          w;
    int          done;
    int          used;
    logic [31:0] f32;
    logic [7:0]  fld;
    logic [7:0]  wide;
    w = width;
    if (w == 0 || w > 8) return '0;
    f32 = (pix >> lsb) & ((32'd1 << w) - 32'd1);
    fld = f32[7:0];
    wide = fld << (8 - w);
    for (done = w; done < 8; done += w) begin
      used = w + done;
      // last copy may not fit: shift it down instead
      if (used <= 8) wide |= fld << (8 - used);
      else wide |= fld >> (used - 8);
    end
    return wide;
  endfunction

  function automatic px_result_t convert_beat(logic req, logic [55:0] d);
    px_result_t res;
    res = '0;
    if (rgb_mode) begin
      if (req == REQ_ENCODE) begin
        res.pixel = place_chan(d[7:0], red_fmt.size, red_fmt.pos)
                  | place_chan(d[15:8], green_fmt.size, green_fmt.pos)
                  | place_chan(d[23:16], blue_fmt.size, blue_fmt.pos);
      end else begin
        res.red   = widen_chan(d[55:24], red_fmt.size, red_fmt.pos);
        res.green = widen_chan(d[55:24], green_fmt.size, green_fmt.pos);
        res.blue  = widen_chan(d[55:24], blue_fmt.size, blue_fmt.pos);
      end
    end
    return res;
  endfunction

  task automatic flag(string what, logic [31:0] want, logic [31:0] got);
    if (error_cnt < 10) begin
      $display("[%0t] %s: expected %h, got %h", $time, what, want, got);
    end
    error_cnt++;
  endtask

  always @(posedge clk) begin : watch
    px_result_t want;
    px_result_t got;
    if (!rst_n) begin
      rgb_mode  = 1'b0;
      red_fmt   = '{pos: 5'd16, size: 4'd8};
      green_fmt = '{pos: 5'd8,  size: 4'd8};
      blue_fmt  = '{pos: 5'd0,  size: 4'd8};
      expected_px.delete();
      pending_cnt = 0;
      error_cnt   = 0;
      checked_cnt = 0;
    end else begin
      // result beat: compare with the oldest prediction
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        checked_cnt++;
        if (expected_px.size() == 0) begin
          flag("result beat with nothing outstanding", '0, got.pixel);
        end else begin
          want = expected_px.pop_front();
          if (got.pixel !== want.pixel) flag("pixel_out", want.pixel, got.pixel);
          if (got.red !== want.red) flag("red_out", want.red, got.red);
          if (got.green !== want.green) flag("green_out", want.green, got.green);
          if (got.blue !== want.blue) flag("blue_out", want.blue, got.blue);
        end
      end
      // input beat: predict with the current format
      if (in_tvalid && in_tready) begin
        expected_px.push_back(convert_beat(in_tuser, in_tdata));
      end
      // register write
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_RGB_MODE:   rgb_mode = cfg_wdata[0];
          REG_RED_POS:    red_fmt.pos = cfg_wdata[4:0];
          REG_RED_SIZE:   red_fmt.size = cfg_wdata[3:0];
          REG_GREEN_POS:  green_fmt.pos = cfg_wdata[4:0];
          REG_GREEN_SIZE: green_fmt.size = cfg_wdata[3:0];
          REG_BLUE_POS:   blue_fmt.pos = cfg_wdata[4:0];
          REG_BLUE_SIZE:  blue_fmt.size = cfg_wdata[3:0];
          default: ;
        endcase
      end
      pending_cnt = expected_px.size();
    end
  end

endmodule

/* tb/sv/tb_top.sv */
// Top of the RGB pixel packer testbench: clock, reset, stimulus, backpressure, verdict.
// Depends on rpfp_pkg, rpfp_tb_pkg, rpfp_result_checker and rgb_pixel_format_packer_core.
module tb_top;
  import rpfp_pkg::*;
  import rpfp_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

  int pending_cnt, error_cnt, checked_cnt;

  // stimulus knobs, set by the main sequence
  int idle_pct, stall_pct;
  int hold_seq, hold_len;
  int n_encode, n_decode, n_formats;

  int          hold_left, seen_seq;
  int unsigned cycle_cnt;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  rgb_pixel_format_packer_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  rpfp_result_checker pixel_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .pending_cnt (pending_cnt),
    .error_cnt   (error_cnt),
    .checked_cnt (checked_cnt)
  );

  // Receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
      seen_seq   <= 0;
    end else if (hold_seq != seen_seq) begin
      seen_seq   <= hold_seq;
      hold_left  <= hold_len;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Offer one beat, idling first at random; returns at the accepting edge
  task automatic push_pixel(px_req_t req, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                            logic [31:0] p);
    logic taken;
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {p, b, g, r};
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end
    if (req == REQ_ENCODE) n_encode++;
    else n_decode++;
  endtask

  // Stop sending and wait for every outstanding result, plus pipeline slack
  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_cnt != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_format(logic mode, logic [4:0] rp, logic [4:0] rs, logic [4:0] gp,
                            logic [4:0] gs, logic [4:0] bp, logic [4:0] bs);
    write_reg(REG_RGB_MODE, {4'd0, mode});
    write_reg(REG_RED_POS, rp);
    write_reg(REG_RED_SIZE, rs);
    write_reg(REG_GREEN_POS, gp);
    write_reg(REG_GREEN_SIZE, gs);
    write_reg(REG_BLUE_POS, bp);
    write_reg(REG_BLUE_SIZE, bs);
    cfg_we <= 1'b0;
    n_formats++;
  endtask

  // Mostly legal widths, sometimes zero or oversized
  function automatic logic [4:0] pick_size();
    int roll;
    roll = $urandom_range(99);
    if (roll < 80) return 5'($urandom_range(8, 1));
    if (roll < 90) return ($urandom_range(1) != 0) ? 5'd8 : 5'd0;
    return 5'($urandom_range(15, 9));
  endfunction

  function automatic logic [7:0] pick_chan();
    if ($urandom_range(7) == 0) return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
    return 8'($urandom_range(255));
  endfunction

  task automatic random_format();
    set_format($urandom_range(7) != 0,
               5'($urandom_range(31)), pick_size(),
               5'($urandom_range(31)), pick_size(),
               5'($urandom_range(31)), pick_size());
  endtask

  task automatic random_run(int count);
    logic [31:0] pix;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(7))
        0:       pix = 32'h0000_0000;
        1:       pix = 32'hFFFF_FFFF;
        default: pix = $urandom();
      endcase
      push_pixel(px_req_t'($urandom_range(1)), pick_chan(), pick_chan(), pick_chan(), pix);
    end
  endtask

  // Main sequence
  initial begin
    int idle_set[4];
    int stall_set[4];
    idle_set  = '{0, 79, 0, 25};
    stall_set = '{0, 0, 79, 25};
    idle_pct  = 0;
    stall_pct = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset format, non-RGB mode: all zero
    push_pixel(REQ_ENCODE, 8'hFF, 8'hFF, 8'hFF, 32'h0);
    push_pixel(REQ_DECODE, 8'h00, 8'h00, 8'h00, 32'hFFFF_FFFF);
    drain();

    // RGB mode on the reset layout (888 at 16/8/0)
    write_reg(REG_RGB_MODE, 5'd1);
    cfg_we <= 1'b0;
    push_pixel(REQ_ENCODE, 8'hFF, 8'hFF, 8'hFF, 32'h0);
    push_pixel(REQ_ENCODE, 8'h00, 8'h00, 8'h00, 32'hFFFF_FFFF);
    push_pixel(REQ_DECODE, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    push_pixel(REQ_DECODE, 8'h00, 8'h00, 8'h00, 32'h0012_3456);
    drain();

    // write to the unused index must not disturb anything; then 565
    write_reg(REG_UNUSED, 5'h1F);
    set_format(1'b1, 5'd11, 5'd5, 5'd5, 5'd6, 5'd0, 5'd5);
    push_pixel(REQ_ENCODE, 8'hFF, 8'h80, 8'h07, 32'hFFFF_FFFF);
    push_pixel(REQ_DECODE, 8'h00, 8'h00, 8'h00, 32'h0000_FFFF);
    push_pixel(REQ_DECODE, 8'h00, 8'h00, 8'h00, 32'h0000_0841);
    drain();

    // widths 1/3/7, red in the top bit: right-shifted last copy, field at the top
    set_format(1'b1, 5'd31, 5'd1, 5'd29, 5'd3, 5'd0, 5'd7);
    push_pixel(REQ_ENCODE, 8'hFF, 8'hA5, 8'hFF, 32'h0);
    push_pixel(REQ_DECODE, 8'h00, 8'h00, 8'h00, 32'hFFFF_FFFF);
    push_pixel(REQ_DECODE, 8'hFF, 8'hFF, 8'hFF, 32'hA000_007F);
    drain();

    // width zero and oversized widths contribute nothing
    set_format(1'b1, 5'd0, 5'd0, 5'd8, 5'd9, 5'd16, 5'd15);
    push_pixel(REQ_ENCODE, 8'hFF, 8'hFF, 8'hFF, 32'h0);
    push_pixel(REQ_DECODE, 8'h00, 8'h00, 8'h00, 32'hFFFF_FFFF);
    drain();

    // overlapping fields, blue running past the pixel top
    set_format(1'b1, 5'd4, 5'd8, 5'd4, 5'd4, 5'd28, 5'd8);
    push_pixel(REQ_ENCODE, 8'h81, 8'hF0, 8'hFF, 32'h0);
    push_pixel(REQ_DECODE, 8'h00, 8'h00, 8'h00, 32'hFFFF_FFFF);
    push_pixel(REQ_DECODE, 8'h00, 8'h00, 8'h00, 32'h5A5A_5A5A);
    drain();

    // widths 2 and 6
    set_format(1'b1, 5'd0, 5'd2, 5'd2, 5'd6, 5'd24, 5'd8);
    push_pixel(REQ_ENCODE, 8'hC0, 8'hFC, 8'h5A, 32'h0);
    push_pixel(REQ_DECODE, 8'h00, 8'h00, 8'h00, 32'hC500_00BE);
    drain();

    // back to non-RGB with an odd layout
    write_reg(REG_RGB_MODE, 5'd0);
    cfg_we <= 1'b0;
    push_pixel(REQ_ENCODE, 8'hFF, 8'hFF, 8'hFF, 32'h0);
    push_pixel(REQ_DECODE, 8'h00, 8'h00, 8'h00, 32'hFFFF_FFFF);
    drain();

    // random phases, four formats each
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_set[ph];
      stall_pct = stall_set[ph];
      for (int run = 0; run < 4; run++) begin
        drain();
        random_format();
        // long receiver hold-off with a busy sender: fills the pipe
        if (ph == 0 && run == 1) begin
          hold_len = 60;
          hold_seq++;
        end
        random_run(40);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("covered %0d beats (%0d encode, %0d decode) over %0d formats", n_encode + n_decode,
             n_encode, n_decode, n_formats);
    $display("%0d results compared, %0d mismatches", checked_cnt, error_cnt);
    if (error_cnt == 0 && pending_cnt == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
